FILE: rtl/laags_pkg.sv
// Package with register map and fixed field widths of the local alignment scorer.
package laags_pkg;

  localparam int SIZE_W = 11;
  localparam int GAP_W  = 13;
  localparam int SUB_W  = 11;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_OPEN  = 3'd2;
  localparam logic [2:0] REG_EXT   = 3'd3;
  localparam logic [2:0] REG_MODE  = 3'd4;

endpackage

FILE: rtl/local_alignment_affine_gap_scorer.sv
// Top level of the local alignment scorer with affine gaps, one matrix cell per request.
//
//   Channel  | Signals                                   | Carries
//   ---------+-------------------------------------------+-------------------------------
//   cell     | cell_valid, cell_ready                    | substitution_score
//   result   | result_valid, result_ready                | best_score, best_row, best_col,
//            |                                           | final_cell_score
//   config   | psel, penable, pwrite, paddr, pwdata,     | five registers at 4*index
//            | prdata, pready                            |
//
// One cell request is taken every cycle unless a waiting result stalls it; the row buffer read for the next cell is
// issued when the current cell is taken, so the buffer's read port sets the rate.
// The result is registered and appears in the cycle after the bottom-right cell is taken.
// Reset is synchronous; a fill count marks which row buffer entries belong to the
// current matrix, so no clearing pass is needed after reset or between matrices.
// A result waiting for result_ready stalls cell requests only when a new result is due.
module local_alignment_affine_gap_scorer #(
  parameter int MAX_LEN     = 1024,
  parameter int SCORE_WIDTH = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [laags_pkg::ADDR_W-1:0]         paddr,
  input  logic [laags_pkg::DATA_W-1:0]         pwdata,
  output logic [laags_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 cell_valid,
  output logic                                 cell_ready,
  input  logic signed [laags_pkg::SUB_W-1:0]   substitution_score,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [SCORE_WIDTH-1:0]        best_score,
  output logic [laags_pkg::SIZE_W-1:0]         best_row,
  output logic [laags_pkg::SIZE_W-1:0]         best_col,
  output logic signed [SCORE_WIDTH-1:0]        final_cell_score
);

  localparam int SW     = SCORE_WIDTH;
  localparam int EW     = (SW > laags_pkg::GAP_W ? SW : laags_pkg::GAP_W) + 2;
  localparam int AW     = $clog2(MAX_LEN);
  localparam int CW     = laags_pkg::SIZE_W;
  localparam int LenCap = MAX_LEN > 2047 ? 2047 : MAX_LEN;
  localparam logic [CW-1:0] LEN_CAP = CW'(LenCap);
  localparam logic signed [EW-1:0] SAT_HI = EW'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [EW-1:0] pick(input logic signed [EW-1:0] a,
                                                input logic signed [EW-1:0] b,
                                                input logic maxi);
    logic b_wins;
    b_wins = maxi ? (b > a) : (b < a);
    return b_wins ? b : a;
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) begin
      r = SW'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = SW'(SAT_LO);
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] size_of(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (v > LEN_CAP) begin
      r = LEN_CAP;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [CW-1:0]                           rows_in_use;
  logic [CW-1:0]                           cols_in_use;
  logic signed [laags_pkg::GAP_W-1:0]      gap_open;
  logic signed [laags_pkg::GAP_W-1:0]      gap_extend;
  logic                                    maximise_mode;

  // Matrix state.
  logic signed [SW-1:0] horizontal_gap;
  logic signed [SW-1:0] left_score;
  logic signed [SW-1:0] diagonal_score;
  logic [CW-1:0]        row_counter;
  logic [CW-1:0]        col_counter;
  logic [CW-1:0]        fill_count;
  logic signed [SW-1:0] best_kept;
  logic [CW-1:0]        best_row_kept;
  logic [CW-1:0]        best_col_kept;
  logic                 rd_valid;
  logic                 byp;
  logic [2*SW-1:0]      byp_data;

  logic                 cfg_write;
  logic [2:0]           cfg_index;
  logic                 accept;
  logic [CW-1:0]        rows_eff;
  logic [CW-1:0]        cols_eff;
  logic                 row_end;
  logic                 matrix_end;
  logic [CW-1:0]        next_col;
  logic [CW-1:0]        fill_next;
  logic [2*SW-1:0]      ram_q;
  logic [2*SW-1:0]      fetched;
  logic signed [SW-1:0] up;
  logic signed [SW-1:0] vert_old;
  logic signed [EW-1:0] go_e;
  logic signed [EW-1:0] ge_e;
  logic signed [SW-1:0] h_new;
  logic signed [SW-1:0] v_new;
  logic signed [SW-1:0] d_new;
  logic signed [EW-1:0] c1;
  logic signed [EW-1:0] c2;
  logic signed [SW-1:0] cell_score;
  logic                 cell_better;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use   <= CW'(1);
      cols_in_use   <= CW'(1);
      gap_open      <= '0;
      gap_extend    <= '0;
      maximise_mode <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        laags_pkg::REG_ROWS: rows_in_use   <= pwdata[CW-1:0];
        laags_pkg::REG_COLS: cols_in_use   <= pwdata[CW-1:0];
        laags_pkg::REG_OPEN: gap_open      <= pwdata[laags_pkg::GAP_W-1:0];
        laags_pkg::REG_EXT:  gap_extend    <= pwdata[laags_pkg::GAP_W-1:0];
        laags_pkg::REG_MODE: maximise_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      laags_pkg::REG_ROWS: prdata = laags_pkg::DATA_W'(rows_in_use);
      laags_pkg::REG_COLS: prdata = laags_pkg::DATA_W'(cols_in_use);
      laags_pkg::REG_OPEN: prdata = laags_pkg::DATA_W'($unsigned(gap_open));
      laags_pkg::REG_EXT:  prdata = laags_pkg::DATA_W'($unsigned(gap_extend));
      laags_pkg::REG_MODE: prdata = laags_pkg::DATA_W'(maximise_mode);
      default:             prdata = '0;
    endcase
  end

  assign cell_ready = !result_valid || result_ready || !matrix_end;
  assign accept     = cell_valid && cell_ready;

  assign rows_eff   = size_of(rows_in_use);
  assign cols_eff   = size_of(cols_in_use);
  assign row_end    = col_counter >= cols_eff;
  assign matrix_end = row_end && (row_counter >= rows_eff);
  assign next_col   = row_end ? CW'(1) : col_counter + CW'(1);
  assign fill_next  = matrix_end ? '0 : (col_counter > fill_count ? col_counter : fill_count);

  assign wr_addr = AW'(col_counter - CW'(1));
  assign rd_addr = AW'(next_col - CW'(1));

  // Entries beyond the fill count were not written in this matrix and read as zero.
  assign fetched  = byp ? byp_data : (rd_valid ? ram_q : '0);
  assign up       = fetched[SW-1:0];
  assign vert_old = fetched[2*SW-1:SW];

  assign go_e  = EW'(gap_open);
  assign ge_e  = EW'(gap_extend);
  assign h_new = sat(pick(EW'(horizontal_gap), EW'(left_score) + go_e, maximise_mode) + ge_e);
  assign v_new = sat(pick(EW'(vert_old), EW'(up) + go_e, maximise_mode) + ge_e);
  assign d_new = sat(EW'(diagonal_score) + EW'(substitution_score));
  assign c1    = pick(EW'(h_new), EW'(d_new), maximise_mode);
  assign c2    = pick(c1, EW'(v_new), maximise_mode);
  assign cell_score = SW'(pick(c2, '0, maximise_mode));

  assign cell_better = maximise_mode ? (cell_score > best_kept) : (cell_score < best_kept);

  laags_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_LEN)
  ) u_row_buf (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_addr),
    .wdata ({v_new, cell_score}),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      horizontal_gap <= '0;
      left_score     <= '0;
      diagonal_score <= '0;
      row_counter    <= CW'(1);
      col_counter    <= CW'(1);
      fill_count     <= '0;
      best_kept      <= '0;
      best_row_kept  <= '0;
      best_col_kept  <= '0;
      rd_valid       <= 1'b0;
      byp            <= 1'b0;
    end else if (accept) begin
      fill_count <= fill_next;
      rd_valid   <= next_col <= fill_next;
      byp        <= !matrix_end && (next_col == col_counter);
      col_counter <= next_col;
      if (row_end) begin
        horizontal_gap <= '0;
        left_score     <= '0;
        diagonal_score <= '0;
      end else begin
        horizontal_gap <= h_new;
        left_score     <= cell_score;
        diagonal_score <= up;
      end
      if (matrix_end) begin
        row_counter   <= CW'(1);
        best_kept     <= '0;
        best_row_kept <= '0;
        best_col_kept <= '0;
      end else begin
        if (row_end) begin
          row_counter <= row_counter + CW'(1);
        end
        if (cell_better) begin
          best_kept     <= cell_score;
          best_row_kept <= row_counter;
          best_col_kept <= col_counter;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data <= {v_new, cell_score};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && matrix_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && matrix_end) begin
      best_score       <= cell_better ? cell_score : best_kept;
      best_row         <= cell_better ? row_counter : best_row_kept;
      best_col         <= cell_better ? col_counter : best_col_kept;
      final_cell_score <= cell_score;
    end
  end

  a_bypass_valid: assert property (@(posedge clk) disable iff (rst) byp |-> rd_valid)
    else $error("Forwarded row entry outside the filled region.");

  a_col_in_fill: assert property (@(posedge clk) disable iff (rst)
    (col_counter != '0) && (col_counter <= fill_count + CW'(1)))
    else $error("Column counter ran ahead of the row buffer fill count.");

  a_matrix_restart: assert property (@(posedge clk) disable iff (rst)
    accept && matrix_end |=> (row_counter == CW'(1)) && (col_counter == CW'(1))
                             && (fill_count == '0) && result_valid)
    else $error("Matrix state not restarted after the last cell.");

endmodule

FILE: rtl/laags_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module laags_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
